### rtl/btnrep_pkg.sv
// Shared types and constants for the button edge and auto-repeat block.
// Used by btnrep_cfg, btnrep_lane and button_edge_and_auto_repeat; depends on nothing.
`default_nettype none

package btnrep_pkg;

	localparam int unsigned MASK_BITS    = 16;
	localparam int unsigned CFG_BITS     = 8;
	localparam int unsigned PHASE_BITS   = 8;
	localparam int unsigned CFG_IDX_BITS = 1;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_DELAY  = 1'b0,
		REG_PERIOD = 1'b1
	} reg_idx_t;

	localparam logic [CFG_BITS-1:0] DEFAULT_DELAY  = 8'd10;
	localparam logic [CFG_BITS-1:0] DEFAULT_PERIOD = 8'd6;

	typedef logic [MASK_BITS-1:0] mask_t;

	typedef struct packed {
		logic [CFG_BITS-1:0] delay;
		logic [CFG_BITS-1:0] period;
	} cfg_t;

endpackage

`default_nettype wire

### rtl/btnrep_cfg.sv
// Configuration registers for the repeat delay and repeat period.
// Depends on btnrep_pkg.
`default_nettype none

module btnrep_cfg (
	input  wire logic                                    clk,
	input  wire logic                                    arst_n,
	input  wire logic                                    wr_en,
	input  wire logic [btnrep_pkg::CFG_IDX_BITS-1:0]     wr_index,
	input  wire logic [btnrep_pkg::CFG_BITS-1:0]         wr_data,
	output btnrep_pkg::cfg_t                             cfg
);
	import btnrep_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.delay  <= DEFAULT_DELAY;
			cfg_q.period <= DEFAULT_PERIOD;
		end else if (wr_en) begin
			unique case (reg_idx_t'(wr_index))
				REG_DELAY: begin
					cfg_q.delay <= wr_data;
				end
				REG_PERIOD: begin
					cfg_q.period <= wr_data;
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

### rtl/btnrep_lane.sv
// Per-button state: press age (saturating) and repeat phase, plus the repeat decision.
// Depends on btnrep_pkg.
`default_nettype none

module btnrep_lane #(
	parameter int unsigned AGE_BITS = 8
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              advance,
	input  wire logic              held,
	input  wire logic              press,
	input  wire btnrep_pkg::cfg_t  cfg,
	output logic                   rep
);
	import btnrep_pkg::*;

	localparam int unsigned CMP_BITS = (AGE_BITS > CFG_BITS) ? AGE_BITS : CFG_BITS;
	localparam logic [AGE_BITS-1:0] AGE_MAX = {AGE_BITS{1'b1}};

	logic [AGE_BITS-1:0]   age_q;
	logic [PHASE_BITS-1:0] phase_q;
	logic [AGE_BITS-1:0]   age_inc;
	logic [PHASE_BITS-1:0] phase_inc;
	logic [AGE_BITS-1:0]   age_d;
	logic [PHASE_BITS-1:0] phase_d;
	logic [PHASE_BITS:0]   phase_next;
	logic                  past_delay;

	always_comb begin
		age_inc    = (age_q == AGE_MAX) ? age_q : age_q + 1'b1;
		phase_next = {1'b0, phase_q} + 1'b1;
		phase_inc  = (phase_next >= {1'b0, cfg.period}) ? '0 : phase_next[PHASE_BITS-1:0];
		past_delay = CMP_BITS'(age_inc) > CMP_BITS'(cfg.delay);
		if (!held || press) begin
			age_d   = '0;
			phase_d = '0;
			rep     = held;
		end else begin
			age_d   = age_inc;
			phase_d = phase_inc;
			rep     = past_delay && (phase_inc == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			age_q   <= '0;
			phase_q <= '0;
		end else if (advance) begin
			age_q   <= age_d;
			phase_q <= phase_d;
		end
	end

endmodule

`default_nettype wire

### rtl/button_edge_and_auto_repeat.sv
// Top level of the button edge and auto-repeat block.
// Depends on btnrep_pkg, btnrep_cfg and btnrep_lane.
// One item (a frame's button word) is accepted every cycle while in_ready is high. Each
// item passes through one input register and then one result register before its result
// is on the outputs. The rate is set by the per-button age and phase update, which is
// combinational logic between those registers. While out_ready is low the two registers
// fill, and in_ready then drops until the result is taken. Buttons at or above
// NUM_BUTTONS, and above bit 15, always read as zero in all three masks.
`default_nettype none

module button_edge_and_auto_repeat #(
	parameter int unsigned NUM_BUTTONS = 16,
	parameter int unsigned AGE_BITS    = 8
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic [btnrep_pkg::MASK_BITS-1:0]    pad_buttons,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic [btnrep_pkg::MASK_BITS-1:0]         held_mask,
	output logic [btnrep_pkg::MASK_BITS-1:0]         press_edge_mask,
	output logic [btnrep_pkg::MASK_BITS-1:0]         repeat_press_mask,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [btnrep_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  wire logic [btnrep_pkg::CFG_BITS-1:0]     cfg_data
);
	import btnrep_pkg::*;

	localparam int unsigned LANES = (NUM_BUTTONS > MASK_BITS) ? MASK_BITS : NUM_BUTTONS;

	cfg_t  cfg;
	logic  valid_s1;
	mask_t pad_s1;
	mask_t prev_q;
	mask_t held;
	mask_t press;
	mask_t rep;
	mask_t lane_mask;
	logic  out_valid_q;
	mask_t held_s2;
	mask_t press_s2;
	mask_t rep_s2;
	logic  s2_free;
	logic  advance;

	assign cfg_ready = 1'b1;

	btnrep_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	assign s2_free  = !out_valid_q || out_ready;
	assign advance  = valid_s1 && s2_free;
	assign in_ready = !valid_s1 || s2_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			pad_s1 <= pad_buttons;
		end
	end

	assign held  = pad_s1 & lane_mask;
	assign press = held & ~prev_q;

	genvar gi;
	generate
		for (gi = 0; gi < MASK_BITS; gi++) begin : g_lane
			if (gi < LANES) begin : g_used
				assign lane_mask[gi] = 1'b1;
				btnrep_lane #(
					.AGE_BITS (AGE_BITS)
				) u_lane (
					.clk     (clk),
					.arst_n  (arst_n),
					.advance (advance),
					.held    (held[gi]),
					.press   (press[gi]),
					.cfg     (cfg),
					.rep     (rep[gi])
				);
			end else begin : g_unused
				assign lane_mask[gi] = 1'b0;
				assign rep[gi]       = 1'b0;
			end
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				prev_q <= held;
			end
			if (s2_free) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			held_s2  <= held;
			press_s2 <= press;
			rep_s2   <= rep;
		end
	end

	assign out_valid         = out_valid_q;
	assign held_mask         = held_s2;
	assign press_edge_mask   = press_s2;
	assign repeat_press_mask = rep_s2;

	a_edge_in_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> ((press_s2 & ~held_s2) == '0))
		else $error("press edge reported for a button that is not held");

	a_edge_repeats: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> ((press_s2 & ~rep_s2) == '0))
		else $error("press edge without a repeat press");

	a_rep_in_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> ((rep_s2 & ~held_s2) == '0))
		else $error("repeat press for a button that is not held");

	a_unused_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (((held_s2 | rep_s2) & ~lane_mask) == '0))
		else $error("unused button reported");

	a_advance_fills: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q)
		else $error("computed item lost between stages");

endmodule

`default_nettype wire

### test/tb_button_edge_and_auto_repeat.sv
`timescale 1ns / 100ps
// Self-checking testbench for button_edge_and_auto_repeat: a directed table and random
// button sequences with random idling and stalls, checked against a typematic predictor.
// Depends on btnrep_pkg and the button_edge_and_auto_repeat RTL.

module tb_button_edge_and_auto_repeat;
	import btnrep_pkg::*;

	localparam int NUM_BUTTONS = 16;
	localparam int AGE_BITS    = 8;
	localparam logic [AGE_BITS-1:0] AGE_MAX = {AGE_BITS{1'b1}};
	localparam int CYCLE_LIMIT   = 200000;
	localparam int HOLD_OFF      = 400;
	localparam int DRAIN_CYCLES  = 8;

	typedef struct packed {
		mask_t held;
		mask_t pressed;
		mask_t repeated;
	} frame_masks_t;

	typedef enum logic {ROW_FRAME, ROW_REG} row_kind_t;

	typedef struct {
		row_kind_t           kind;
		reg_idx_t            idx;
		logic [CFG_BITS-1:0] value;
		mask_t               pad;
		bit                  known;
		frame_masks_t        want;
	} dir_row_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	mask_t               pad_buttons = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	mask_t               held_mask;
	mask_t               press_edge_mask;
	mask_t               repeat_press_mask;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	reg_idx_t            cfg_index = REG_DELAY;
	logic [CFG_BITS-1:0] cfg_data = '0;

	logic [CFG_BITS-1:0]   model_delay = DEFAULT_DELAY;
	logic [CFG_BITS-1:0]   model_period = DEFAULT_PERIOD;
	mask_t                 model_levels = '0;
	logic [AGE_BITS-1:0]   model_age [NUM_BUTTONS];
	logic [PHASE_BITS-1:0] model_phase [NUM_BUTTONS];

	frame_masks_t pending_masks [$];
	dir_row_t     directed_rows [$];
	int           mismatch_count = 0;
	int           frames_sent = 0;
	int           burst_left = 0;
	int           cycle_count = 0;
	bit           hold_off_done = 1'b0;

	button_edge_and_auto_repeat #(
		.NUM_BUTTONS(NUM_BUTTONS),
		.AGE_BITS   (AGE_BITS)
	) u_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.pad_buttons      (pad_buttons),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.held_mask        (held_mask),
		.press_edge_mask  (press_edge_mask),
		.repeat_press_mask(repeat_press_mask),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data)
	);

	always #5 clk = ~clk;

	initial begin
		for (int i = 0; i < NUM_BUTTONS; i++) begin
			model_age[i] = '0;
			model_phase[i] = '0;
		end
	end

	function automatic frame_masks_t typematic_step(input mask_t pad);
		frame_masks_t    r;
		logic [PHASE_BITS:0] next_phase;
		r.held = pad;
		r.pressed = pad & ~model_levels;
		r.repeated = '0;
		for (int i = 0; i < NUM_BUTTONS; i++) begin
			if (!pad[i]) begin
				model_age[i] = '0;
				model_phase[i] = '0;
			end else if (r.pressed[i]) begin
				model_age[i] = '0;
				model_phase[i] = '0;
				r.repeated[i] = 1'b1;
			end else begin
				if (model_age[i] != AGE_MAX)
					model_age[i] = model_age[i] + 1'b1;
				next_phase = {1'b0, model_phase[i]} + 1'b1;
				if (next_phase >= {1'b0, model_period})
					model_phase[i] = '0;
				else
					model_phase[i] = next_phase[PHASE_BITS-1:0];
				if (model_age[i] > model_delay && model_phase[i] == '0)
					r.repeated[i] = 1'b1;
			end
		end
		model_levels = pad;
		return r;
	endfunction

	task automatic row_frame(input mask_t pad);
		dir_row_t row;
		row.kind = ROW_FRAME;
		row.idx = REG_DELAY;
		row.value = '0;
		row.pad = pad;
		row.known = 1'b0;
		row.want = '0;
		directed_rows.push_back(row);
	endtask

	task automatic row_known(input mask_t pad, input mask_t h, input mask_t p, input mask_t r);
		dir_row_t row;
		row.kind = ROW_FRAME;
		row.idx = REG_DELAY;
		row.value = '0;
		row.pad = pad;
		row.known = 1'b1;
		row.want.held = h;
		row.want.pressed = p;
		row.want.repeated = r;
		directed_rows.push_back(row);
	endtask

	task automatic row_reg(input reg_idx_t idx, input logic [CFG_BITS-1:0] value);
		dir_row_t row;
		row.kind = ROW_REG;
		row.idx = idx;
		row.value = value;
		row.pad = '0;
		row.known = 1'b0;
		row.want = '0;
		directed_rows.push_back(row);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [CFG_BITS-1:0] value);
		in_valid <= 1'b0;
		while (pending_masks.size() != 0)
			@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		if (idx == REG_DELAY)
			model_delay = value;
		else
			model_period = value;
	endtask

	task automatic send_frame(input mask_t pad, input bit known, input frame_masks_t want);
		int           gap;
		frame_masks_t predicted;
		cfg_valid <= 1'b0;
		if (burst_left == 0) begin
			gap = $urandom_range(8);
			burst_left = $urandom_range(24, 1);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		in_valid <= 1'b1;
		pad_buttons <= pad;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		burst_left--;
		frames_sent++;
		predicted = typematic_step(pad);
		pending_masks.push_back(known ? want : predicted);
	endtask

	task automatic run_phase(input logic [CFG_BITS-1:0] dly, input logic [CFG_BITS-1:0] per,
			input int flip_div, input bit noisy, input int count);
		mask_t pad;
		mask_t levels;
		write_reg(REG_DELAY, dly);
		write_reg(REG_PERIOD, per);
		levels = (flip_div > 256) ? '1 : mask_t'($urandom);
		for (int n = 0; n < count; n++) begin
			if (noisy && $urandom_range(15) == 0) begin
				pad = mask_t'($urandom);
			end else begin
				for (int b = 0; b < NUM_BUTTONS; b++)
					if ($urandom_range(flip_div - 1) == 0)
						levels[b] = ~levels[b];
				pad = levels;
			end
			send_frame(pad, 1'b0, '0);
		end
	endtask

	initial begin
		row_known(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		row_known(16'h0000, 16'h0000, 16'h0000, 16'h0000);
		row_known(16'h0001, 16'h0001, 16'h0001, 16'h0001);
		row_known(16'h8000, 16'h8000, 16'h8000, 16'h8000);
		row_frame(16'hA5A5);
		row_frame(16'hFFFF);
		row_frame(16'hFFFF);
		row_reg(REG_DELAY, 8'd0);
		row_reg(REG_PERIOD, 8'd1);
		row_frame(16'hFFFF);
		row_frame(16'hFFFF);
		row_frame(16'hFFFF);
		row_reg(REG_PERIOD, 8'd0);
		row_frame(16'hFFFF);
		row_frame(16'hFFFF);
		row_reg(REG_PERIOD, 8'd6);
		row_frame(16'hFFFF);
		row_frame(16'hFFFF);
		row_frame(16'hFFFF);
		row_reg(REG_PERIOD, 8'd2);
		row_frame(16'hFFFF);
		row_frame(16'hFFFF);
		row_reg(REG_DELAY, 8'd254);
		row_reg(REG_PERIOD, 8'd255);
		row_known(16'h0000, 16'h0000, 16'h0000, 16'h0000);
		row_known(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		row_frame(16'hFFFF);
		row_frame(16'h5A5A);
		row_reg(REG_DELAY, 8'd255);
		row_reg(REG_PERIOD, 8'd1);
		row_frame(16'h3C3C);
		row_frame(16'h3C3C);
		row_known(16'h0000, 16'h0000, 16'h0000, 16'h0000);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_REG)
				write_reg(directed_rows[i].idx, directed_rows[i].value);
			else
				send_frame(directed_rows[i].pad, directed_rows[i].known, directed_rows[i].want);
		end

		run_phase(DEFAULT_DELAY, DEFAULT_PERIOD, 8, 1'b1, 175);
		run_phase(8'd0, 8'd1, 16, 1'b1, 175);
		run_phase(8'd0, 8'd0, 16, 1'b1, 175);
		run_phase(8'd2, 8'd255, 32, 1'b1, 175);
		run_phase(8'd254, 8'd3, 1024, 1'b0, 300);
		run_phase(8'd255, 8'd4, 1024, 1'b0, 300);
		run_phase(CFG_BITS'($urandom_range(20)), CFG_BITS'($urandom_range(10, 1)), 8, 1'b1, 175);
		run_phase(CFG_BITS'($urandom), CFG_BITS'($urandom), 4, 1'b1, 175);

		in_valid <= 1'b0;
		while (pending_masks.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin
		int mode;
		mode = 0;
		forever begin
			@(posedge clk);
			if (cycle_count % 64 == 0)
				mode = $urandom_range(3);
			if (!hold_off_done && frames_sent >= 500) begin
				hold_off_done = 1'b1;
				out_ready <= 1'b0;
				repeat (HOLD_OFF) @(posedge clk);
			end else begin
				case (mode)
					0: out_ready <= 1'b1;
					1: out_ready <= ($urandom_range(3) != 0);
					2: out_ready <= ($urandom_range(1) != 0);
					default: out_ready <= cycle_count[1];
				endcase
			end
		end
	end

	always @(posedge clk) begin : check_results
		frame_masks_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_masks.size() == 0) begin
				$error("result with no expectation: held %h edge %h repeat %h",
					held_mask, press_edge_mask, repeat_press_mask);
				mismatch_count++;
			end else begin
				want = pending_masks.pop_front();
				if (held_mask !== want.held) begin
					$error("held_mask: expected %h, actual %h", want.held, held_mask);
					mismatch_count++;
				end
				if (press_edge_mask !== want.pressed) begin
					$error("press_edge_mask: expected %h, actual %h",
						want.pressed, press_edge_mask);
					mismatch_count++;
				end
				if (repeat_press_mask !== want.repeated) begin
					$error("repeat_press_mask: expected %h, actual %h",
						want.repeated, repeat_press_mask);
					mismatch_count++;
				end
			end
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("DONE: errors detected");
		$finish;
	end

endmodule
